// ===== design/ldpf_pkg.sv =====
// Shared types and constants for the page framebuffer line drawer.
package ldpf_pkg;

  localparam int X_W         = 7;
  localparam int Y_W         = 6;
  localparam int PG_W        = 3;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 8;
  localparam int ERR_W       = 10;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam logic [BYTE_W-1:0] PIX_ONE = 8'h01;

  typedef struct packed {
    logic [X_W-1:0]  read_column;
    logic [PG_W-1:0] read_page;
    logic            clear_pixels;
    logic [Y_W-1:0]  y_end;
    logic [X_W-1:0]  x_end;
    logic [Y_W-1:0]  y_start;
    logic [X_W-1:0]  x_start;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic draw_step;
    logic rd_issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic draw_last;
  } sts_t;

endpackage

// ===== design/ldpf_dp.sv =====
// Datapath: frame memory, clearing counter, line stepper, read-modify-write stage, result register.
module ldpf_dp #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ldpf_pkg::cmd_t                      cmd_i,
  output ldpf_pkg::sts_t                      sts_o,
  input  ldpf_pkg::item_t                     item_i,
  input  logic                                func_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_flip_i,
  output logic [ldpf_pkg::OUT_TDATA_W-1:0]    out_data_o
);
  import ldpf_pkg::*;

  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = 9;
  localparam logic [CMP_W-1:0]  COLS_L    = CMP_W'(COLUMNS);
  localparam logic [CMP_W-1:0]  PAGES_L   = CMP_W'(PAGES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [BYTE_W-1:0] mem_wd;

  logic [ADDR_W-1:0] clr_cnt_q;
  logic              flip_q;

  // line stepper
  logic [X_W-1:0]    cur_x_q, dx_q;
  logic [Y_W-1:0]    cur_y_q;
  logic [X_W-1:0]    dy_q, remain_q;
  logic [ERR_W-1:0]  err_q;
  logic              x_major_q, sx_neg_q, sy_neg_q, clr_q;
  logic [CNT_W-1:0]  count_q;

  // read item
  logic              is_read_q, rd_ok_q;
  logic [ADDR_W-1:0] rd_addr_q;

  // write stage and forwarding
  logic              vb_q, fv_q;
  logic [ADDR_W-1:0] ab_q, fa_q;
  logic [BYTE_W-1:0] mb_q, fd_q;

  logic [OUT_TDATA_W-1:0] out_q;

  // setup terms
  logic              x_fwd, y_fwd, xmaj0;
  logic [X_W-1:0]    dx0, dy0, len0;
  logic [Y_W-1:0]    dy0_n;
  logic              rd_ok0;
  logic [ADDR_W-1:0] rd_addr0;

  // step terms
  logic [X_W-1:0]    minor_len, major_len;
  logic [ERR_W-1:0]  err_sum, err_nxt;
  logic              step_minor, in_range;
  logic [PG_W-1:0]   pg_a;
  logic [ADDR_W-1:0] pix_addr;
  logic [2:0]        bitpos;
  logic [BYTE_W-1:0] pix_mask, base, merged;

  always_comb begin
    x_fwd    = item_i.x_end > item_i.x_start;
    y_fwd    = item_i.y_end > item_i.y_start;
    dx0      = x_fwd ? item_i.x_end - item_i.x_start : item_i.x_start - item_i.x_end;
    dy0_n    = y_fwd ? item_i.y_end - item_i.y_start : item_i.y_start - item_i.y_end;
    dy0      = {1'b0, dy0_n};
    xmaj0    = dx0 > dy0;
    len0     = xmaj0 ? dx0 : dy0;
    rd_ok0   = ({{(CMP_W-PG_W){1'b0}}, item_i.read_page} < PAGES_L) &&
               ({{(CMP_W-X_W){1'b0}}, item_i.read_column} < COLS_L);
    rd_addr0 = ADDR_W'(32'(item_i.read_page) * COLUMNS + 32'(item_i.read_column));
  end

  always_comb begin
    minor_len  = x_major_q ? dy_q : dx_q;
    major_len  = x_major_q ? dx_q : dy_q;
    err_sum    = err_q + {2'b0, minor_len, 1'b0};
    step_minor = ~err_sum[ERR_W-1];
    err_nxt    = step_minor ? err_sum - {2'b0, major_len, 1'b0} : err_sum;
    pg_a       = cur_y_q[Y_W-1:3];
    in_range   = ({{(CMP_W-X_W){1'b0}}, cur_x_q} < COLS_L) &&
                 ({{(CMP_W-PG_W){1'b0}}, pg_a} < PAGES_L);
    pix_addr   = ADDR_W'(32'(pg_a) * COLUMNS + 32'(cur_x_q));
    bitpos     = cur_y_q[2:0] ^ {3{flip_q}};
    pix_mask   = PIX_ONE << bitpos;
    // read of this byte may have missed the write of the previous pixel
    base       = (fv_q && (fa_q == ab_q)) ? fd_q : rdata_q;
    merged     = clr_q ? (base & ~mb_q) : (base | mb_q);
  end

  always_comb begin
    mem_we = cmd_i.clr_step | vb_q;
    mem_wa = cmd_i.clr_step ? clr_cnt_q : ab_q;
    mem_wd = cmd_i.clr_step ? '0 : merged;
    mem_re = (cmd_i.draw_step & in_range) | cmd_i.rd_issue;
    mem_ra = cmd_i.rd_issue ? rd_addr_q : pix_addr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      flip_q    <= 1'b0;
      vb_q      <= 1'b0;
      fv_q      <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_we_i) begin
        flip_q <= cfg_flip_i;
      end
      vb_q <= cmd_i.draw_step & in_range;
      fv_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_x_q   <= item_i.x_start;
      cur_y_q   <= item_i.y_start;
      dx_q      <= dx0;
      dy_q      <= dy0;
      remain_q  <= len0;
      err_q     <= ERR_W'(0) - {{(ERR_W-X_W){1'b0}}, len0};
      x_major_q <= xmaj0;
      sx_neg_q  <= ~x_fwd;
      sy_neg_q  <= ~y_fwd;
      clr_q     <= item_i.clear_pixels;
      count_q   <= '0;
      is_read_q <= func_i;
      rd_ok_q   <= rd_ok0;
      rd_addr_q <= rd_addr0;
    end else if (cmd_i.draw_step) begin
      if (x_major_q || step_minor) begin
        cur_x_q <= sx_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
      if (!x_major_q || step_minor) begin
        cur_y_q <= sy_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
      err_q    <= err_nxt;
      remain_q <= remain_q - 1'b1;
      if (in_range) begin
        count_q <= count_q + 1'b1;
      end
    end
    ab_q <= pix_addr;
    mb_q <= pix_mask;
    fa_q <= ab_q;
    fd_q <= merged;
    if (cmd_i.load_out) begin
      if (is_read_q) begin
        out_q <= {{CNT_W{1'b0}}, rd_ok_q ? rdata_q : {BYTE_W{1'b0}}};
      end else begin
        out_q <= {count_q, {BYTE_W{1'b0}}};
      end
    end
  end

  assign sts_o.clr_last  = (clr_cnt_q == LAST_ADDR);
  assign sts_o.draw_last = (remain_q == '0);
  assign out_data_o      = out_q;

endmodule

// ===== design/ldpf_ctrl.sv =====
// Controller: sequences clearing, line walk, byte read and result hand-off.
module ldpf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_func_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ldpf_pkg::sts_t sts_i,
  output ldpf_pkg::cmd_t cmd_o
);
  import ldpf_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_free   = ~out_valid_q | out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = in_func_i ? ST_READ : ST_DRAW;
        end
      end
      ST_DRAW: begin
        cmd_o.draw_step = 1'b1;
        if (sts_i.draw_last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/line_draw_into_page_framebuffer.sv =====
// Draw item: N = max(|dx|,|dy|)+1 pixels are stepped; the next input is taken after the result is loaded.
// One byte read-modify-write per in-range pixel, pipelined through the frame memory port (one pixel/cycle).
// Read item: the byte read is registered, then loaded as the result once the output is free.
// A result waiting in the output register does not block the next input transfer.
// After reset a clearing pass zeroes all PAGES*COLUMNS bytes of the frame (1024 by default),
// with s_axis_tready low; configuration writes are taken at any time.
module line_draw_into_page_framebuffer #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // x_start, y_start, x_end, y_end, clear_pixels, read_page, read_column
  input  logic [ldpf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_data, pixels_drawn
  output logic [ldpf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_data_i
);
  import ldpf_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  item_t item;

  assign item        = item_t'(s_axis_tdata[ITEM_W-1:0]);
  assign cfg_ready_o = 1'b1;

  ldpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_func_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ldpf_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .item_i     (item),
    .func_i     (s_axis_tuser),
    .cfg_we_i   (cfg_valid_i),
    .cfg_flip_i (cfg_data_i),
    .out_data_o (m_axis_tdata)
  );

endmodule
